// ===== rtl/dmc_pkg.sv =====
package dmc_pkg;

    // fixed field widths
    localparam int ADDR_W = 10;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 8;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ACCESS = 1'b1;

    // configuration register indexes
    localparam logic CFG_HIT_TIME     = 1'b0;
    localparam logic CFG_MISS_PENALTY = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] HIT_TIME_RST     = 8'd1;
    localparam logic [CFG_W-1:0] MISS_PENALTY_RST = 8'd10;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_FILL_LAST,
        ST_RESULT
    } t_state;

    // counter update request from the sequencer
    typedef struct packed {
        logic upd;
        logic miss;
    } t_stat_evt;

endpackage

// ===== rtl/dmc_ram.sv =====
module dmc_ram import dmc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/dmc_stats.sv =====
module dmc_stats import dmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stat_evt         i_evt,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic [CNT_W-1:0]  o_miss_count,
    output logic [CNT_W-1:0]  o_access_count,
    output logic [TIME_W-1:0] o_total_time
);

    logic [CFG_W-1:0]  r_hit_time;
    logic [CFG_W-1:0]  r_miss_penalty;
    logic [CNT_W-1:0]  r_misses;
    logic [CNT_W-1:0]  r_accesses;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  n_misses;
    logic [CNT_W-1:0]  n_accesses;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W:0]   time_sum;
    logic [CFG_W-1:0]  time_inc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_time     <= HIT_TIME_RST;
            r_miss_penalty <= MISS_PENALTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIT_TIME:     r_hit_time     <= i_cfg_data;
                CFG_MISS_PENALTY: r_miss_penalty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturating counters
    always_comb begin
        time_inc   = i_evt.miss ? r_miss_penalty : r_hit_time;
        time_sum   = {1'b0, r_time} + (TIME_W+1)'(time_inc);
        n_time     = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
        n_accesses = (&r_accesses) ? r_accesses : r_accesses + 1'b1;
        n_misses   = (&r_misses) ? r_misses : r_misses + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_misses   <= '0;
            r_accesses <= '0;
            r_time     <= '0;
        end else if (i_evt.upd) begin
            r_accesses <= n_accesses;
            r_time     <= n_time;
            if (i_evt.miss) begin
                r_misses <= n_misses;
            end
        end
    end

    assign o_miss_count   = r_misses;
    assign o_access_count = r_accesses;
    assign o_total_time   = r_time;

    // every miss is also an access
    a_miss_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_misses <= r_accesses)
        else $error("miss count above access count");

    // a saturated time stays saturated
    a_time_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_time) |=> (&r_time))
        else $error("total time left saturation");

endmodule

// ===== rtl/direct_mapped_cache_lookup.sv =====
// Direct-mapped read-only cache in front of a byte-wide backing store.
// A load item (op 0) writes one backing byte; an access item (op 1) looks up
// the line picked by the address, refills it on a miss and returns the hit
// flag, the addressed byte and the saturating miss, access and time counters.
// One item is in flight at a time: a load passes through the result state,
// a hit through lookup and result, a miss through lookup, refill, last fill
// and result until its result is in the output register; then the next item
// is accepted. The miss time is set by the single-port backing store that
// delivers one byte of the refill per cycle. The output register lets the
// next item be accepted while a result still waits. All parameters must be
// powers of two; backing store indices wrap modulo STORE_BYTES. The memories
// hold no reset state: per-line valid bits in flip-flops stand in for the
// tags and line data until a line is first filled, so no clearing pass runs.
module direct_mapped_cache_lookup import dmc_pkg::*; #(
    parameter int NUM_LINES   = 4,
    parameter int BLOCK_BYTES = 8,
    parameter int STORE_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_load_byte,
    // result item channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_hit,
    output logic [DATA_W-1:0] o_read_byte,
    output logic [CNT_W-1:0]  o_miss_count,
    output logic [CNT_W-1:0]  o_access_count,
    output logic [TIME_W-1:0] o_total_time,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int WB     = $clog2(BLOCK_BYTES);
    localparam int LB     = $clog2(NUM_LINES);
    localparam int LINE_W = (LB > 0) ? LB : 1;
    localparam int TAG_W  = (ADDR_W > WB + LB) ? ADDR_W - WB - LB : 1;
    localparam int SB_W   = $clog2(STORE_BYTES);
    localparam int LD_W   = $clog2(NUM_LINES * BLOCK_BYTES);
    localparam int EXT_W  = ADDR_W + WB + LB + SB_W;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [WB-1:0]     r_rd_idx;
    logic [WB-1:0]     r_wr_idx;
    logic              r_wr_pend;
    logic              r_hit;
    logic [DATA_W-1:0] r_rdata;
    logic [NUM_LINES-1:0] r_line_valid;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_byte;
    logic [CNT_W-1:0]  r_out_miss;
    logic [CNT_W-1:0]  r_out_access;
    logic [TIME_W-1:0] r_out_time;

    logic [ADDR_W-1:0] cur_addr;
    logic [EXT_W-1:0]  ext_addr;
    logic [WB-1:0]     word;
    logic [LINE_W-1:0] line;
    logic [TAG_W-1:0]  tag;
    logic              accept;
    logic              lookup_hit;
    logic              out_load;
    logic              fill_step;
    t_stat_evt         stat_evt;

    logic              bs_we;
    logic [SB_W-1:0]   bs_addr;
    logic [DATA_W-1:0] bs_rdata;
    logic              tag_we;
    logic [TAG_W-1:0]  tag_rdata;
    logic              ld_we;
    logic [LD_W-1:0]   ld_addr;
    logic [DATA_W-1:0] ld_rdata;

    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  access_count;
    logic [TIME_W-1:0] total_time;

    // address split: the live input while idle, the held item afterwards
    always_comb begin
        cur_addr = (r_state == ST_IDLE) ? i_address : r_addr;
        ext_addr = EXT_W'(cur_addr);
        word     = ext_addr[WB-1:0];
        line     = LINE_W'((ext_addr >> WB) & EXT_W'(NUM_LINES - 1));
        tag      = TAG_W'(ext_addr >> (WB + LB));
    end

    assign accept     = i_valid && (r_state == ST_IDLE);
    assign lookup_hit = r_line_valid[line] && (tag_rdata == tag);

    // sequencer next state and strobes
    always_comb begin
        n_state      = r_state;
        out_load     = 1'b0;
        fill_step    = 1'b0;
        tag_we       = 1'b0;
        stat_evt.upd  = 1'b0;
        stat_evt.miss = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_op == OP_LOAD) ? ST_RESULT : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                stat_evt.upd  = 1'b1;
                stat_evt.miss = !lookup_hit;
                tag_we        = !lookup_hit;
                n_state       = lookup_hit ? ST_RESULT : ST_FILL;
            end
            ST_FILL: begin
                fill_step = 1'b1;
                if (r_rd_idx == WB'(BLOCK_BYTES - 1)) begin
                    n_state = ST_FILL_LAST;
                end
            end
            ST_FILL_LAST: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                out_load = !r_out_valid || !i_stall;
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item context and refill bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend    <= 1'b0;
            r_line_valid <= '0;
        end else begin
            r_wr_pend <= fill_step;
            if (tag_we) begin
                r_line_valid[line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= i_address;
            r_hit   <= 1'b0;
            r_rdata <= '0;
        end
        if (r_state == ST_LOOKUP) begin
            r_hit    <= lookup_hit;
            r_rdata  <= ld_rdata;
            r_rd_idx <= '0;
        end
        if (fill_step) begin
            r_rd_idx <= r_rd_idx + 1'b1;
            r_wr_idx <= r_rd_idx;
        end
        // pick the addressed byte off the refill stream
        if (r_wr_pend && (r_wr_idx == word)) begin
            r_rdata <= bs_rdata;
        end
    end

    // backing store port: load writes while idle, refill reads otherwise
    assign bs_we   = accept && (i_op == OP_LOAD);
    assign bs_addr = (r_state == ST_IDLE) ? SB_W'(ext_addr)
                   : SB_W'(((ext_addr >> WB) << WB) | EXT_W'(r_rd_idx));

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (bs_we),
        .i_addr  (bs_addr),
        .i_wdata (i_load_byte),
        .o_rdata (bs_rdata)
    );

    dmc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LINES)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_addr  (line),
        .i_wdata (tag),
        .o_rdata (tag_rdata)
    );

    // line data port: read of the addressed byte while idle, refill writes
    assign ld_we   = r_wr_pend;
    assign ld_addr = (LD_W'(line) << WB) | LD_W'(r_wr_pend ? r_wr_idx : word);

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_LINES * BLOCK_BYTES)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_addr  (ld_addr),
        .i_wdata (bs_rdata),
        .o_rdata (ld_rdata)
    );

    dmc_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (stat_evt),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_miss_count   (miss_count),
        .o_access_count (access_count),
        .o_total_time   (total_time)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit    <= r_hit;
            r_out_byte   <= r_rdata;
            r_out_miss   <= miss_count;
            r_out_access <= access_count;
            r_out_time   <= total_time;
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_read_byte    = r_out_byte;
    assign o_miss_count   = r_out_miss;
    assign o_access_count = r_out_access;
    assign o_total_time   = r_out_time;

    // line data is only written by a refill
    a_ld_write_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_we |-> (r_state == ST_FILL || r_state == ST_FILL_LAST))
        else $error("line data written outside a refill");

    // backing store only written by an accepted load
    a_bs_write_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bs_we |-> (i_valid && !o_stall && i_op == OP_LOAD))
        else $error("backing store written without a load item");

    // refill finishes with the last byte of the line in flight
    a_fill_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL_LAST) |-> (r_wr_pend && r_wr_idx == WB'(BLOCK_BYTES - 1)))
        else $error("refill ended early");

    // a miss leaves its line valid
    a_miss_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && !lookup_hit) |=> (r_state == ST_FILL && r_line_valid[$past(line)]))
        else $error("missed line not marked valid");

endmodule
